// File: rtl/rme_pkg.sv
// Shared constants, types and helpers for the modular exponentiation unit.
package rme_pkg;

    localparam int MOD_BITS = 27;
    localparam int CNT_W    = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;
    localparam int DATA_W   = (MOD_BITS > 32) ? 64 : 32;
    localparam int ADDR_W   = (MOD_BITS > 32) ? 5 : 4;
    localparam int AB       = (MOD_BITS > 32) ? 3 : 2;

    // Register index codes
    localparam logic [1:0] REG_MODULUS  = 2'd0;
    localparam logic [1:0] REG_PUB_EXP  = 2'd1;
    localparam logic [1:0] REG_PRIV_EXP = 2'd2;

    // Command codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [MOD_BITS-1:0] word_t;

    // Start request to a modular multiplier
    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
        word_t m;
    } mm_req_t;

    // Completion status from a modular multiplier
    typedef struct packed {
        logic  done;
        word_t r;
    } mm_rsp_t;

    // (x + y) mod m for x, y < m
    function automatic word_t add_mod(input word_t x, input word_t y, input word_t m);
        logic [MOD_BITS:0] s;
        begin
            s = {1'b0, x} + {1'b0, y};
            if (s >= {1'b0, m})
            begin
                s = s - {1'b0, m};
            end
            return s[MOD_BITS-1:0];
        end
    endfunction

endpackage

// File: rtl/rsa_modular_exponentiation_unit.sv
// Top level: register port, exponent sequencer and result register.
//
// Usage: program modulus (0x0), public exponent (0x4) and private exponent
// (0x8) over the APB port while the unit is idle. Each input beat carries a
// command (0 encrypt with the public exponent, 1 decrypt with the private one)
// and a value; one output beat returns value^exponent mod modulus.
// The value is first reduced with one bit-serial pass that ends with a done
// flag. Each exponent bit then runs a multiply and a squaring side by side
// on two bit-serial multipliers, then a done flag and one check state; the
// number of these rounds is the bit length of the exponent.
// One item is in work at a time; in_ready is high when the sequencer is idle.
// A modulus of 0 or 1 gives 0 without a multiplier pass; a zero exponent gives 1.
// The result sits in an output register: if the receiver stalls, the next
// item is still taken, and a finished result waits until that register frees.
// Reset clears the registers to modulus 1 and both exponents 0 and drops all
// valid flags.
module rsa_modular_exponentiation_unit
    import rme_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [MOD_BITS-1:0] value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [MOD_BITS-1:0] result
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_MUL    = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t  state_reg, state_next;
    word_t   modulus_reg, pub_exp_reg, priv_exp_reg;
    word_t   ex_reg, ex_next;
    word_t   acc_reg, acc_next;
    word_t   base_reg, base_next;
    word_t   result_reg, result_next;
    logic    out_valid_reg, out_valid_next;
    logic    cfg_wr;
    logic    in_beat;
    logic    start_red, start_mul;
    mm_req_t req_acc, req_sq;
    mm_rsp_t rsp_acc, rsp_sq;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= word_t'(1);
            pub_exp_reg  <= '0;
            priv_exp_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[AB+1:AB])
                REG_MODULUS:  modulus_reg  <= MOD_BITS'(pwdata);
                REG_PUB_EXP:  pub_exp_reg  <= MOD_BITS'(pwdata);
                REG_PRIV_EXP: priv_exp_reg <= MOD_BITS'(pwdata);
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[AB+1:AB])
            REG_MODULUS:  prdata = DATA_W'(modulus_reg);
            REG_PUB_EXP:  prdata = DATA_W'(pub_exp_reg);
            REG_PRIV_EXP: prdata = DATA_W'(priv_exp_reg);
            default:      prdata = '0;
        endcase
    end

    // Multipliers: one for the accumulator (also reduces the input), one squares
    assign req_acc.start = start_red | start_mul;
    assign req_acc.a     = start_red ? word_t'(1) : acc_reg;
    assign req_acc.b     = start_red ? value : base_reg;
    assign req_acc.m     = modulus_reg;
    assign req_sq.start  = start_mul;
    assign req_sq.a      = base_reg;
    assign req_sq.b      = base_reg;
    assign req_sq.m      = modulus_reg;

    rme_mulmod u_mul_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_acc),
        .rsp   (rsp_acc)
    );

    rme_mulmod u_mul_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_sq),
        .rsp   (rsp_sq)
    );

    // Control and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        ex_reg     <= ex_next;
        acc_reg    <= acc_next;
        base_reg   <= base_next;
        result_reg <= result_next;
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_beat  = in_valid & in_ready;

    // Right-to-left square-and-multiply sequencer
    always_comb
    begin
        state_next     = state_reg;
        ex_next        = ex_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        start_red      = 1'b0;
        start_mul      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    ex_next = (command == CMD_DECRYPT) ? priv_exp_reg : pub_exp_reg;
                    if (modulus_reg <= word_t'(1))
                    begin
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        start_red  = 1'b1;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (rsp_acc.done)
                begin
                    base_next  = rsp_acc.r;
                    acc_next   = word_t'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (ex_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    start_mul  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (rsp_acc.done)
                begin
                    if (ex_reg[0])
                    begin
                        acc_next = rsp_acc.r;
                    end
                    base_next  = rsp_sq.r;
                    ex_next    = ex_reg >> 1;
                    state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    result_next    = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// File: rtl/rme_mulmod.sv
// Bit-serial interleaved modular multiplier: a doubling and an add phase per bit of b.
module rme_mulmod
    import rme_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mm_req_t req,
    output mm_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    word_t             a_reg, a_next;
    word_t             b_reg, b_next;
    word_t             m_reg, m_next;
    word_t             r_reg, r_next;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        cnt_reg   <= cnt_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        m_reg     <= m_next;
        r_reg     <= r_next;
    end

    // Phase 0 doubles the partial result, phase 1 adds a if the top bit of b is set
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        m_next     = m_reg;
        r_next     = r_reg;
        if (req.start)
        begin
            a_next     = req.a;
            b_next     = req.b;
            m_next     = req.m;
            r_next     = '0;
            cnt_next   = CNT_W'(MOD_BITS - 1);
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                r_next     = add_mod(r_reg, r_reg, m_reg);
                phase_next = 1'b1;
            end
            else
            begin
                if (b_reg[MOD_BITS-1])
                begin
                    r_next = add_mod(r_reg, a_reg, m_reg);
                end
                b_next     = b_reg << 1;
                phase_next = 1'b0;
                if (cnt_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.r    = r_reg;

endmodule
